@@ hw/rtl/nwom_pkg.sv @@
// Package for the nth-weekday-of-month block: shared types, codes and calendar tables.
// Used by nwom_calendar, nwom_select and nth_weekday_of_month_top; depends on nothing.

package nwom_pkg;

	// Selection codes of a request; the fourth code means nothing and yields an error
	typedef enum logic [1:0] {
		CMD_NTH    = 2'd0,
		CMD_TEENTH = 2'd1,
		CMD_LAST   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	// Configuration register indexes
	localparam logic REG_YEAR  = 1'b0;
	localparam logic REG_MONTH = 1'b1;

	localparam logic [13:0] YEAR_RESET  = 14'd2000;
	localparam logic [3:0]  MONTH_RESET = 4'd1;

	// floor(x / 100) for x below 2^15 is (x * 5243) >> 19
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int unsigned RECIP_SHIFT = 19;

	// Weekday of the 13th relative to the 1st; the last day's shift comes from last_shift
	localparam logic [2:0] TEENTH_SHIFT = 3'd5;

	// Day-of-week state handed from the calendar stages to the selection stages
	typedef struct packed {
		logic       valid;
		logic [1:0] cmd;
		logic [2:0] weekday;
		logic [2:0] ordinal;
		logic [4:0] len;
		logic [5:0] fold;
		logic       bad;
	} cal_t;

	// Reduce a value of at most 13 to its residue mod 7
	function automatic logic [2:0] mod7_small(input logic [3:0] v);
		logic [3:0] r;
		r = (v >= 4'd7) ? (v - 4'd7) : v;
		return r[2:0];
	endfunction

	// Month key for the day-of-week sum, January is 1
	function automatic logic [2:0] month_offset(input logic [3:0] m);
		logic [2:0] r;
		case (m)
			4'd1:    r = 3'd0;
			4'd2:    r = 3'd3;
			4'd3:    r = 3'd2;
			4'd4:    r = 3'd5;
			4'd5:    r = 3'd0;
			4'd6:    r = 3'd3;
			4'd7:    r = 3'd5;
			4'd8:    r = 3'd1;
			4'd9:    r = 3'd4;
			4'd10:   r = 3'd6;
			4'd11:   r = 3'd2;
			4'd12:   r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			4'd2:    r = leap ? 5'd29 : 5'd28;
			4'd4:    r = 5'd30;
			4'd6:    r = 5'd30;
			4'd9:    r = 5'd30;
			4'd11:   r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

	// (len - 1) mod 7 for lengths 28 to 31
	function automatic logic [2:0] last_shift(input logic [4:0] len);
		logic [2:0] r;
		case (len)
			5'd28:   r = 3'd6;
			5'd29:   r = 3'd0;
			5'd30:   r = 3'd1;
			default: r = 3'd2;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/nwom_calendar.sv @@
// Calendar stages 1 and 2: shifted year, century quotients, leap year, month length
// and the octal-folded day-of-week sum of the 1st. Depends on nwom_pkg.

module nwom_calendar (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       command,
	input  logic [2:0]       weekday,
	input  logic [2:0]       ordinal,
	input  logic [13:0]      year,
	input  logic [3:0]       month,
	output nwom_pkg::cal_t   cal
);

	logic [14:0] yy;
	logic [27:0] yy_prod;
	logic [26:0] yr_prod;

	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [2:0]  wd_s1;
	logic [2:0]  ord_s1;
	logic [3:0]  month_s1;
	logic [13:0] year_s1;
	logic [14:0] yy_s1;
	logic [7:0]  yyq100_s1;
	logic [7:0]  yrq100_s1;

	logic [14:0] yr_hund;
	logic [13:0] r100;
	logic        leap;
	logic [14:0] dow_sum;
	logic [5:0]  fold;
	logic        bad;

	logic        valid_s2;
	logic [1:0]  cmd_s2;
	logic [2:0]  wd_s2;
	logic [2:0]  ord_s2;
	logic [4:0]  len_s2;
	logic [5:0]  fold_s2;
	logic        bad_s2;

	// Step back one year for January and February; 400 years is a whole number of weeks
	assign yy = {1'b0, year} + 15'd400 - ((month < 4'd3) ? 15'd1 : 15'd0);
	assign yy_prod = 28'(yy) * 28'(nwom_pkg::RECIP_100);
	assign yr_prod = 27'(year) * 27'(nwom_pkg::RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1    <= command;
		wd_s1     <= weekday;
		ord_s1    <= ordinal;
		month_s1  <= month;
		year_s1   <= year;
		yy_s1     <= yy;
		yyq100_s1 <= yy_prod[nwom_pkg::RECIP_SHIFT +: 8];
		yrq100_s1 <= yr_prod[nwom_pkg::RECIP_SHIFT +: 8];
	end

	always_comb begin
		yr_hund = 15'(yrq100_s1) * 15'd100;
		r100    = year_s1 - yr_hund[13:0];
		leap    = ((year_s1[1:0] == 2'd0) && (r100 != 14'd0)) ||
			((r100 == 14'd0) && (yrq100_s1[1:0] == 2'd0));
		dow_sum = yy_s1 + {2'b00, yy_s1[14:2]} - {7'd0, yyq100_s1}
			+ {9'd0, yyq100_s1[7:2]} + {12'd0, nwom_pkg::month_offset(month_s1)} + 15'd1;
		// 8 is 1 mod 7, so the octal digits sum to the same residue
		fold    = {3'd0, dow_sum[2:0]} + {3'd0, dow_sum[5:3]} + {3'd0, dow_sum[8:6]}
			+ {3'd0, dow_sum[11:9]} + {3'd0, dow_sum[14:12]};
		bad     = (wd_s1 == 3'd7) || (month_s1 == 4'd0) || (month_s1 > 4'd12)
			|| (cmd_s1 == nwom_pkg::CMD_UNUSED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2  <= cmd_s1;
		wd_s2   <= wd_s1;
		ord_s2  <= ord_s1;
		len_s2  <= nwom_pkg::month_length(month_s1, leap);
		fold_s2 <= fold;
		bad_s2  <= bad;
	end

	assign cal = {valid_s2, cmd_s2, wd_s2, ord_s2, len_s2, fold_s2, bad_s2};

endmodule

@@ hw/rtl/nwom_select.sv @@
// Selection stages 3 and 4: weekday of the 1st, offset to the target weekday per
// selection, then the day of month and the range check. Depends on nwom_pkg.

module nwom_select (
	input  logic           clk,
	input  logic           arst_n,
	input  nwom_pkg::cal_t cal,
	output logic           done,
	output logic [4:0]     day_of_month,
	output logic           status
);

	logic [2:0] first;
	logic [2:0] w13;
	logic [2:0] wl;
	logic [2:0] off;

	logic       valid_s3;
	logic [1:0] cmd_s3;
	logic [2:0] ord_s3;
	logic [4:0] len_s3;
	logic [2:0] off_s3;
	logic       bad_s3;

	logic [5:0] nth_day;
	logic [5:0] day;
	logic       found;

	logic       done_s4;
	logic [4:0] day_s4;
	logic       status_s4;

	always_comb begin
		first = nwom_pkg::mod7_small({1'b0, cal.fold[2:0]} + {1'b0, cal.fold[5:3]});
		w13   = nwom_pkg::mod7_small({1'b0, first} + {1'b0, nwom_pkg::TEENTH_SHIFT});
		wl    = nwom_pkg::mod7_small({1'b0, first} + {1'b0, nwom_pkg::last_shift(cal.len)});
		case (cal.cmd)
			nwom_pkg::CMD_NTH:
				off = nwom_pkg::mod7_small(4'd7 + {1'b0, cal.weekday} - {1'b0, first});
			nwom_pkg::CMD_TEENTH:
				off = nwom_pkg::mod7_small(4'd7 + {1'b0, cal.weekday} - {1'b0, w13});
			default:
				off = nwom_pkg::mod7_small(4'd7 + {1'b0, wl} - {1'b0, cal.weekday});
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= cal.valid;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s3 <= cal.cmd;
		ord_s3 <= cal.ordinal;
		len_s3 <= cal.len;
		off_s3 <= off;
		bad_s3 <= cal.bad;
	end

	always_comb begin
		nth_day = 6'd1 + {3'd0, off_s3} + 6'd7 * ({3'd0, ord_s3} - 6'd1);
		case (cmd_s3)
			nwom_pkg::CMD_NTH: begin
				day   = nth_day;
				found = (ord_s3 != 3'd0) && (nth_day <= {1'b0, len_s3});
			end
			nwom_pkg::CMD_TEENTH: begin
				day   = 6'd13 + {3'd0, off_s3};
				found = 1'b1;
			end
			nwom_pkg::CMD_LAST: begin
				day   = {1'b0, len_s3} - {3'd0, off_s3};
				found = 1'b1;
			end
			default: begin
				day   = 6'd0;
				found = 1'b0;
			end
		endcase
		if (bad_s3) begin
			found = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= valid_s3;
		end
	end

	// Drop the day on a miss
	always_ff @(posedge clk) begin
		day_s4    <= found ? day[4:0] : 5'd0;
		status_s4 <= ~found;
	end

	assign done         = done_s4;
	assign day_of_month = day_s4;
	assign status       = status_s4;

endmodule

@@ hw/rtl/nth_weekday_of_month_top.sv @@
// done rises once the request has passed four register stages (valid_s1, valid_s2,
// valid_s3, done_s4); throughput is one request per cycle.
// busy is always low: the pipeline never stalls, and every result shows for one cycle only.
// Reset (arst_n low) empties the pipeline and sets year 2000, month 1.
// Top level of the nth-weekday-of-month block: configuration registers and the two
// pipeline halves. Depends on nwom_pkg, nwom_calendar and nwom_select.

module nth_weekday_of_month_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [13:0] wr_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [2:0]  weekday,
	input  logic [2:0]  ordinal,
	output logic        done,
	output logic [4:0]  day_of_month,
	output logic        status
);

	logic [13:0] year_q;
	logic [3:0]  month_q;

	nwom_pkg::cal_t cal;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= nwom_pkg::YEAR_RESET;
			month_q <= nwom_pkg::MONTH_RESET;
		end else if (wr_en) begin
			if (wr_index == nwom_pkg::REG_YEAR) begin
				year_q <= wr_data;
			end
			if (wr_index == nwom_pkg::REG_MONTH) begin
				month_q <= wr_data[3:0];
			end
		end
	end

	assign busy = 1'b0;

	nwom_calendar u_calendar (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.weekday (weekday),
		.ordinal (ordinal),
		.year    (year_q),
		.month   (month_q),
		.cal     (cal)
	);

	nwom_select u_select (
		.clk          (clk),
		.arst_n       (arst_n),
		.cal          (cal),
		.done         (done),
		.day_of_month (day_of_month),
		.status       (status)
	);

endmodule
